// ===== hdl/icysd_pkg.sv =====
// ----------------------------------------------------------------------------
// ICY stream demux package
// Shared types, status line and header key text, and byte kind codes.
// ----------------------------------------------------------------------------
package icysd_pkg;

    // Byte kind codes carried on the result word.
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_AUDIO  = 3'd1;
    localparam logic [2:0] KIND_LENGTH = 3'd2;
    localparam logic [2:0] KIND_META   = 3'd3;
    localparam logic [2:0] KIND_DROP   = 3'd4;

    // Control characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Status line candidates, left aligned in a 17-character field.
    localparam int unsigned STAT_CHARS = 17;
    localparam logic [8*STAT_CHARS-1:0] STAT_ICY    = {"ICY 200 OK\r\n", 40'h0};
    localparam logic [8*STAT_CHARS-1:0] STAT_HTTP10 = "HTTP/1.0 200 OK\r\n";
    localparam logic [8*STAT_CHARS-1:0] STAT_HTTP11 = "HTTP/1.1 200 OK\r\n";
    localparam logic [4:0] STAT_ICY_LAST  = 5'd11;
    localparam logic [4:0] STAT_HTTP_LAST = 5'd16;

    // Header key that announces the metadata interval (lower case).
    localparam logic [8*12-1:0] META_KEY = "icy-metaint:";
    localparam logic [4:0] META_KEY_LAST = 5'd11;

    // Body phase, one-hot.
    typedef enum logic [6:0] {
        PH_STATUS = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_AUDIO  = 7'b0000100,
        PH_LENGTH = 7'b0001000,
        PH_META   = 7'b0010000,
        PH_PLAIN  = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

    // Which parsing phase the control unit is in.
    typedef struct packed {
        logic in_status;
        logic in_header;
    } phase_view_t;

    // Events that the header parser reports for the current byte.
    typedef struct packed {
        logic status_fail;
        logic status_fin;
        logic header_end;
    } hdr_evt_t;

    // Character of a status candidate at a line position; zero past the end.
    function automatic logic [7:0] stat_char(input logic [8*STAT_CHARS-1:0] s,
                                             input logic [4:0] pos);
        logic [4:0] idx;
        idx = STAT_HTTP_LAST - pos;
        if (pos > STAT_HTTP_LAST)
        begin
            return 8'h00;
        end
        return s[{idx, 3'b000} +: 8];
    endfunction

    // Character of the header key at a line position; zero past the end.
    function automatic logic [7:0] key_char(input logic [4:0] pos);
        logic [4:0] idx;
        idx = META_KEY_LAST - pos;
        if (pos > META_KEY_LAST)
        begin
            return 8'h00;
        end
        return META_KEY[{idx[3:0], 3'b000} +: 8];
    endfunction

    // Saturating line position increment.
    function automatic logic [4:0] pos_inc(input logic [4:0] pos);
        return (pos == 5'd31) ? pos : pos + 5'd1;
    endfunction

endpackage

// ===== hdl/icysd_header.sv =====
// ----------------------------------------------------------------------------
// ICY stream demux header parser
// Matches the status line, tracks header lines and parses the interval value.
// ----------------------------------------------------------------------------
module icysd_header #(
    parameter int COUNT_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  icysd_pkg::phase_view_t    ph,
    input  logic [7:0]                stream_byte,
    output icysd_pkg::hdr_evt_t       evt,
    output logic [COUNT_BITS-1:0]     interval_value
);
    import icysd_pkg::*;

    logic [2:0]            flags_reg, flags_next;
    logic [4:0]            pos_reg, pos_next;
    logic                  pm_reg, pm_next;
    logic                  cr_reg, cr_next;
    logic [COUNT_BITS-1:0] iv_reg, iv_next;

    logic [2:0]            cand_hit;
    logic                  status_fin;
    logic [4:0]            pos_a, pos_b;
    logic                  pm_a, pm_b;
    logic [7:0]            folded;
    logic                  in_key, key_hit, is_digit;
    logic [COUNT_BITS+3:0] iv_wide;
    logic [COUNT_BITS-1:0] iv_sat, iv_b;

    // Status line: each candidate survives while its next character matches.
    always_comb
    begin
        cand_hit[0] = flags_reg[0] && (pos_reg <= STAT_ICY_LAST)
                      && (stream_byte == stat_char(STAT_ICY, pos_reg));
        cand_hit[1] = flags_reg[1] && (pos_reg <= STAT_HTTP_LAST)
                      && (stream_byte == stat_char(STAT_HTTP10, pos_reg));
        cand_hit[2] = flags_reg[2] && (pos_reg <= STAT_HTTP_LAST)
                      && (stream_byte == stat_char(STAT_HTTP11, pos_reg));
        status_fin  = (cand_hit[0] && pos_reg == STAT_ICY_LAST)
                      || (cand_hit[1] && pos_reg == STAT_HTTP_LAST)
                      || (cand_hit[2] && pos_reg == STAT_HTTP_LAST);
    end

    // Header line content. A pending CR that is not followed by LF counts
    // as an ordinary line byte first, then the current byte is applied.
    always_comb
    begin
        pos_a    = cr_reg ? pos_inc(pos_reg) : pos_reg;
        pm_a     = (cr_reg && pos_reg <= META_KEY_LAST) ? 1'b0 : pm_reg;
        folded   = (stream_byte >= "A" && stream_byte <= "Z") ?
                   (stream_byte | 8'h20) : stream_byte;
        in_key   = (pos_a <= META_KEY_LAST);
        key_hit  = (folded == key_char(pos_a));
        is_digit = (stream_byte >= "0") && (stream_byte <= "9");
        pm_b     = (in_key && !key_hit) ? 1'b0 : pm_a;
        pos_b    = pos_inc(pos_a);

        // Decimal accumulate: value * 10 + digit, saturating.
        iv_wide  = {1'b0, iv_reg, 3'b000} + {3'b000, iv_reg, 1'b0}
                   + (COUNT_BITS+4)'(stream_byte[3:0]);
        iv_sat   = (iv_wide[COUNT_BITS+3:COUNT_BITS] != 4'd0) ?
                   {COUNT_BITS{1'b1}} : iv_wide[COUNT_BITS-1:0];

        if (in_key && key_hit && pos_a == META_KEY_LAST && pm_a)
        begin
            iv_b = '0;
        end
        else if (!in_key && pm_a && is_digit)
        begin
            iv_b = iv_sat;
        end
        else
        begin
            iv_b = iv_reg;
        end
    end

    // Next state for the status and header phases.
    always_comb
    begin
        flags_next = flags_reg;
        pos_next   = pos_reg;
        pm_next    = pm_reg;
        cr_next    = cr_reg;
        iv_next    = iv_reg;
        if (ph.in_status)
        begin
            flags_next = cand_hit;
            if (cand_hit != 3'b000)
            begin
                if (status_fin)
                begin
                    pos_next = 5'd0;
                    pm_next  = 1'b1;
                    cr_next  = 1'b0;
                end
                else
                begin
                    pos_next = pos_inc(pos_reg);
                end
            end
        end
        else if (ph.in_header)
        begin
            if (cr_reg && stream_byte == CH_LF)
            begin
                cr_next = 1'b0;
                if (pos_reg != 5'd0)
                begin
                    pos_next = 5'd0;
                    pm_next  = 1'b1;
                end
            end
            else if (stream_byte == CH_CR)
            begin
                cr_next  = 1'b1;
                pos_next = pos_a;
                pm_next  = pm_a;
            end
            else
            begin
                cr_next  = 1'b0;
                pos_next = pos_b;
                pm_next  = pm_b;
                iv_next  = iv_b;
            end
        end
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 3'b111;
            pos_reg   <= 5'd0;
            pm_reg    <= 1'b1;
            cr_reg    <= 1'b0;
            iv_reg    <= '0;
        end
        else if (step)
        begin
            flags_reg <= flags_next;
            pos_reg   <= pos_next;
            pm_reg    <= pm_next;
            cr_reg    <= cr_next;
            iv_reg    <= iv_next;
        end
    end

    // Events for the control unit.
    assign evt.status_fail = (cand_hit == 3'b000);
    assign evt.status_fin  = status_fin;
    assign evt.header_end  = cr_reg && (stream_byte == CH_LF) && (pos_reg == 5'd0);
    assign interval_value  = iv_reg;

endmodule

// ===== hdl/icysd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ICY stream demux control
// Phase sequencer and run counter that tag each byte of the stream.
// ----------------------------------------------------------------------------
module icysd_ctrl #(
    parameter int COUNT_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              stream_byte,
    input  icysd_pkg::hdr_evt_t     evt,
    input  logic [COUNT_BITS-1:0]   interval_value,
    input  logic                    metadata_enable,
    output icysd_pkg::phase_view_t  ph,
    output logic [2:0]              byte_kind,
    output logic                    bad_response,
    output logic                    header_done
);
    import icysd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] rem_dec;
    logic                  run_last;

    // The run ends on the byte that takes the count to zero.
    assign rem_dec  = (rem_reg != '0) ? rem_reg - COUNT_BITS'(1) : rem_reg;
    assign run_last = (rem_reg <= COUNT_BITS'(1));

    // Phase sequencing and byte tagging.
    always_comb
    begin
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        byte_kind   = KIND_HEADER;
        header_done = 1'b0;
        case (phase_reg)
            PH_STATUS:
            begin
                if (evt.status_fail)
                begin
                    phase_next = PH_ERROR;
                    byte_kind  = KIND_DROP;
                end
                else if (evt.status_fin)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (evt.header_end)
                begin
                    header_done = 1'b1;
                    if (!metadata_enable && interval_value != '0)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (!metadata_enable || interval_value == '0)
                    begin
                        phase_next = PH_PLAIN;
                    end
                    else
                    begin
                        phase_next = PH_AUDIO;
                        rem_next   = interval_value;
                    end
                end
            end
            PH_AUDIO:
            begin
                byte_kind = KIND_AUDIO;
                rem_next  = rem_dec;
                if (run_last)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                byte_kind = KIND_LENGTH;
                if (stream_byte == 8'd0)
                begin
                    phase_next = PH_AUDIO;
                    rem_next   = interval_value;
                end
                else
                begin
                    phase_next = PH_META;
                    rem_next   = COUNT_BITS'({stream_byte, 4'b0000});
                end
            end
            PH_META:
            begin
                byte_kind = KIND_META;
                rem_next  = rem_dec;
                if (run_last)
                begin
                    phase_next = PH_AUDIO;
                    rem_next   = interval_value;
                end
            end
            PH_PLAIN:
            begin
                byte_kind = KIND_AUDIO;
            end
            default:
            begin
                phase_next = PH_ERROR;
                byte_kind  = KIND_DROP;
            end
        endcase
    end

    // Phase and run count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STATUS;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
        end
    end

    assign bad_response = (phase_next == PH_ERROR);
    assign ph.in_status = (phase_reg == PH_STATUS);
    assign ph.in_header = (phase_reg == PH_HEADER);

endmodule

// ===== hdl/icy_stream_metadata_demux.sv =====
// ----------------------------------------------------------------------------
// ICY stream metadata demultiplexer
// Tags each byte of an ICY or HTTP radio response as header, audio,
// metadata length, metadata or dropped.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  input     in_valid / in_ready      stream_byte
//  output    out_valid / out_ready    byte_kind, data_out, bad_response,
//                                     header_done
//  config    cfg_write                metadata_enable
//
//  One word is accepted per cycle while the output register is free or being
//  emptied; its result appears in the output register on the next cycle.
//  The parser and phase state are updated in the same cycle the word is taken.
//  While the output register holds a word that is not taken, in_ready drops.
//  Reset returns the block to status line matching with metadata enabled.
// ----------------------------------------------------------------------------
module icy_stream_metadata_demux #(
    parameter int COUNT_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       metadata_enable,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] byte_kind,
    output logic [7:0] data_out,
    output logic       bad_response,
    output logic       header_done
);
    import icysd_pkg::*;

    logic                  meta_en_reg;
    logic                  step;
    phase_view_t           ph;
    hdr_evt_t              evt;
    logic [COUNT_BITS-1:0] interval_value;
    logic [2:0]            kind_next;
    logic                  bad_next;
    logic                  done_next;

    logic                  out_valid_reg;
    logic [2:0]            kind_reg;
    logic [7:0]            data_reg;
    logic                  bad_reg;
    logic                  done_reg;

    // A word is taken when the output register is free or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_en_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            meta_en_reg <= metadata_enable;
        end
    end

    // Status line and header parser.
    icysd_header #(
        .COUNT_BITS (COUNT_BITS)
    ) u_header (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .ph             (ph),
        .stream_byte    (stream_byte),
        .evt            (evt),
        .interval_value (interval_value)
    );

    // Phase sequencer and run counter.
    icysd_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .stream_byte     (stream_byte),
        .evt             (evt),
        .interval_value  (interval_value),
        .metadata_enable (meta_en_reg),
        .ph              (ph),
        .byte_kind       (kind_next),
        .bad_response    (bad_next),
        .header_done     (done_next)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg <= kind_next;
            data_reg <= stream_byte;
            bad_reg  <= bad_next;
            done_reg <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_kind    = kind_reg;
    assign data_out     = data_reg;
    assign bad_response = bad_reg;
    assign header_done  = done_reg;

endmodule

// ===== hdl/icysd_checker.sv =====
// ----------------------------------------------------------------------------
// ICY stream demux checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module icysd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] byte_kind,
    input logic [7:0] data_out,
    input logic       bad_response,
    input logic       header_done
);
    import icysd_pkg::*;

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_kind)
            && $stable(data_out) && $stable(bad_response) && $stable(header_done))
        else $error("result word changed while stalled");

    // Once an error is reported, every later word reports it too.
    a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && bad_response |=> !out_valid || bad_response)
        else $error("error flag cleared after an error");

    // The header end is always on a header byte.
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_done |-> byte_kind == KIND_HEADER)
        else $error("header end on a non-header byte");

    // Dropped bytes only come with the error flag.
    a_drop_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_DROP |-> bad_response)
        else $error("dropped byte without error flag");

    // Body bytes never carry the error flag.
    a_body_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_kind == KIND_AUDIO || byte_kind == KIND_LENGTH
            || byte_kind == KIND_META) |-> !bad_response)
        else $error("body byte with error flag");

endmodule

bind icy_stream_metadata_demux icysd_checker u_icysd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_kind    (byte_kind),
    .data_out     (data_out),
    .bad_response (bad_response),
    .header_done  (header_done)
);
